@@ rtl/sfs_pkg.sv @@
// Shared types, register indexes, codes and reset values of the safety fault supervisor.
`default_nettype none

package sfs_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam int DAY_THRESHOLD_BITS = 12;
	localparam int MAX_FAULTS_BITS = 3;
	localparam int TIMEOUT_BITS = 16;
	localparam int PERIOD_BITS = 10;
	localparam int CODE_BITS = 3;
	localparam int COUNT_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DAY_THRESHOLD = 3'd0,
		REG_MAX_FAULTS    = 3'd1,
		REG_LINK_TIMEOUT  = 3'd2,
		REG_TOLERANT      = 3'd3,
		REG_TICK_PERIOD   = 3'd4
	} cfg_index_e;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_WARNING  = 2'd1,
		STATUS_DEGRADED = 2'd2,
		STATUS_SAFE     = 2'd3
	} status_e;

	typedef enum logic [CODE_BITS-1:0] {
		REASON_NONE      = 3'd0,
		REASON_MULTI     = 3'd1,
		REASON_LINK      = 3'd2,
		REASON_WATCHDOG  = 3'd3,
		REASON_INTERVAL  = 3'd4
	} reason_e;

	localparam logic [CODE_BITS-1:0] WDG_OK = 3'd0;
	localparam logic [CODE_BITS-1:0] WDG_FAILED = 3'd1;
	localparam logic [CODE_BITS-1:0] WDG_EXPIRED = 3'd2;

	localparam logic [CODE_BITS-1:0] EXT_NONE = 3'd0;
	localparam logic [CODE_BITS-1:0] EXT_MAX = 3'd4;

	localparam logic [CFG_DATA_BITS-1:0] DAY_THRESHOLD_RST = 16'd2048;
	localparam logic [MAX_FAULTS_BITS-1:0] MAX_FAULTS_RST = 3'd2;
	localparam logic [TIMEOUT_BITS-1:0] LINK_TIMEOUT_RST = 16'd100;
	localparam logic [TIMEOUT_BITS-1:0] TOLERANT_RST = 16'd200;
	localparam logic [PERIOD_BITS-1:0] TICK_PERIOD_RST = 10'd10;

	localparam logic [COUNT_BITS-1:0] DEGRADED_COUNT = 3'd2;

	typedef struct packed {
		logic [MAX_FAULTS_BITS-1:0] max_faults;
		logic [TIMEOUT_BITS-1:0]    link_timeout_ms;
		logic [TIMEOUT_BITS-1:0]    tolerant_interval_ms;
		logic [PERIOD_BITS-1:0]     tick_period_ms;
	} cfg_t;

	typedef struct packed {
		logic                 switch_valid;
		logic                 link_check_valid;
		logic                 ambient_valid;
		logic                 lamp_fault;
		logic [CODE_BITS-1:0] watchdog_status;
		logic [CODE_BITS-1:0] ext_reason;
	} tick_flags_t;

	typedef struct packed {
		logic [1:0]            global_status;
		logic                  in_safe_state;
		logic [CODE_BITS-1:0]  safe_reason;
		logic                  safe_lamp_command;
		logic [COUNT_BITS-1:0] fault_count;
		logic                  safe_entered_now;
		logic                  watchdog_fault;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/sfs_if.sv @@
// Handshake interfaces for the tick, result and configuration channels.
`default_nettype none

interface sfs_tick_if #(
	parameter int SAMPLE_BITS = sfs_pkg::SAMPLE_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic                           switch_valid;
	logic                           link_check_valid;
	logic                           ambient_valid;
	logic [SAMPLE_BITS-1:0]         ambient_level;
	logic                           lamp_fault;
	logic [sfs_pkg::CODE_BITS-1:0]  watchdog_status;
	logic [sfs_pkg::CODE_BITS-1:0]  ext_reason;

	modport source (
		output valid, switch_valid, link_check_valid, ambient_valid, ambient_level,
			lamp_fault, watchdog_status, ext_reason,
		input ready
	);
	modport sink (
		input valid, switch_valid, link_check_valid, ambient_valid, ambient_level,
			lamp_fault, watchdog_status, ext_reason,
		output ready
	);
endinterface

interface sfs_result_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     global_status;
	logic                           in_safe_state;
	logic [sfs_pkg::CODE_BITS-1:0]  safe_reason;
	logic                           safe_lamp_command;
	logic [sfs_pkg::COUNT_BITS-1:0] fault_count;
	logic                           safe_entered_now;
	logic                           watchdog_fault;

	modport source (
		output valid, global_status, in_safe_state, safe_reason, safe_lamp_command,
			fault_count, safe_entered_now, watchdog_fault,
		input ready
	);
	modport sink (
		input valid, global_status, in_safe_state, safe_reason, safe_lamp_command,
			fault_count, safe_entered_now, watchdog_fault,
		output ready
	);
endinterface

interface sfs_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sfs_pkg::CFG_INDEX_BITS-1:0] index;
	logic [sfs_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (
		output valid, index, data,
		input ready
	);
	modport sink (
		input valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/sfs_state.sv @@
// Supervision state, fault timers, safe-state latch and per-tick result evaluation.
`default_nettype none

module sfs_state #(
	parameter int TIME_BITS = sfs_pkg::TIME_BITS_DEF,
	parameter int SAMPLE_BITS = sfs_pkg::SAMPLE_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     adv,
	input  sfs_pkg::tick_flags_t    flags,
	input  wire [SAMPLE_BITS-1:0]   level,
	input  sfs_pkg::cfg_t           cfg,
	input  wire [SAMPLE_BITS-1:0]   day_threshold,
	output sfs_pkg::result_t        res
);

	logic [TIME_BITS-1:0]                   time_q;
	logic [TIME_BITS-1:0]                   first_fault_q;
	logic                                   interval_run_q;
	logic [sfs_pkg::COUNT_BITS-1:0]         prev_count_q;
	logic [TIME_BITS-1:0]                   link_start_q;
	logic                                   link_run_q;
	logic                                   safe_latched_q;
	logic [sfs_pkg::CODE_BITS-1:0]          reason_q;
	logic                                   lamp_q;
	logic                                   day_q;

	logic [TIME_BITS-1:0]                   period_ext;
	logic [sfs_pkg::COUNT_BITS-1:0]         count;
	logic                                   wdg_fault;
	logic                                   day_d;
	logic [TIME_BITS-1:0]                   first_fault_d;
	logic                                   interval_run_d;
	logic [TIME_BITS-1:0]                   link_start_d;
	logic                                   link_run_d;
	logic                                   ext_trig;
	logic                                   multi_trig;
	logic                                   link_trig;
	logic                                   wdg_trig;
	logic                                   interval_trig;
	logic [sfs_pkg::CODE_BITS-1:0]          ext_code;
	logic [sfs_pkg::CODE_BITS-1:0]          trig_reason;
	logic                                   any_trig;
	logic                                   safe_latched_d;
	logic [sfs_pkg::CODE_BITS-1:0]          reason_d;
	logic                                   lamp_d;
	logic [TIME_BITS-1:0]                   link_elapsed;
	logic [TIME_BITS-1:0]                   fault_elapsed;

	assign period_ext = TIME_BITS'(cfg.tick_period_ms);

	always_comb begin
		wdg_fault = (flags.watchdog_status != sfs_pkg::WDG_OK);
		count = sfs_pkg::COUNT_BITS'(!flags.switch_valid)
			+ sfs_pkg::COUNT_BITS'(!flags.ambient_valid)
			+ sfs_pkg::COUNT_BITS'(flags.lamp_fault)
			+ sfs_pkg::COUNT_BITS'(wdg_fault);

		day_d = flags.ambient_valid ? (level > day_threshold) : day_q;

		ext_trig = (flags.ext_reason != sfs_pkg::EXT_NONE);
		ext_code = (flags.ext_reason > sfs_pkg::EXT_MAX) ? sfs_pkg::EXT_MAX : flags.ext_reason;

		first_fault_d = first_fault_q;
		interval_run_d = interval_run_q;
		if (count != '0 && prev_count_q == '0) begin
			first_fault_d = time_q;
			interval_run_d = 1'b1;
		end
		if (count == '0) begin
			interval_run_d = 1'b0;
		end
		multi_trig = (count >= cfg.max_faults);

		link_elapsed = time_q - link_start_q;
		link_start_d = link_start_q;
		link_run_d = link_run_q;
		link_trig = 1'b0;
		if (!flags.link_check_valid) begin
			if (!link_run_q) begin
				link_start_d = time_q;
				link_run_d = 1'b1;
			end else begin
				link_trig = (link_elapsed >= TIME_BITS'(cfg.link_timeout_ms));
			end
		end else begin
			link_run_d = 1'b0;
		end

		wdg_trig = (flags.watchdog_status inside {sfs_pkg::WDG_FAILED, sfs_pkg::WDG_EXPIRED});

		fault_elapsed = time_q - first_fault_d;
		interval_trig = interval_run_d
			&& (fault_elapsed >= TIME_BITS'(cfg.tolerant_interval_ms));

		any_trig = ext_trig || multi_trig || link_trig || wdg_trig || interval_trig;
		if (ext_trig) begin
			trig_reason = ext_code;
		end else if (multi_trig) begin
			trig_reason = sfs_pkg::REASON_MULTI;
		end else if (link_trig) begin
			trig_reason = sfs_pkg::REASON_LINK;
		end else if (wdg_trig) begin
			trig_reason = sfs_pkg::REASON_WATCHDOG;
		end else begin
			trig_reason = sfs_pkg::REASON_INTERVAL;
		end

		safe_latched_d = safe_latched_q || any_trig;
		reason_d = (!safe_latched_q && any_trig) ? trig_reason : reason_q;
		lamp_d = safe_latched_d ? !day_d : lamp_q;

		res.in_safe_state = safe_latched_d;
		res.safe_reason = reason_d;
		res.safe_lamp_command = lamp_d;
		res.fault_count = count;
		res.safe_entered_now = !safe_latched_q && any_trig;
		res.watchdog_fault = wdg_fault;
		if (safe_latched_d) begin
			res.global_status = sfs_pkg::STATUS_SAFE;
		end else if (count >= sfs_pkg::DEGRADED_COUNT) begin
			res.global_status = sfs_pkg::STATUS_DEGRADED;
		end else if (count != '0) begin
			res.global_status = sfs_pkg::STATUS_WARNING;
		end else begin
			res.global_status = sfs_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			first_fault_q <= '0;
			interval_run_q <= 1'b0;
			prev_count_q <= '0;
			link_start_q <= '0;
			link_run_q <= 1'b0;
			safe_latched_q <= 1'b0;
			reason_q <= sfs_pkg::REASON_NONE;
			lamp_q <= 1'b0;
			day_q <= 1'b1;
		end else if (adv) begin
			time_q <= time_q + period_ext;
			first_fault_q <= first_fault_d;
			interval_run_q <= interval_run_d;
			prev_count_q <= count;
			link_start_q <= link_start_d;
			link_run_q <= link_run_d;
			safe_latched_q <= safe_latched_d;
			reason_q <= reason_d;
			lamp_q <= lamp_d;
			day_q <= day_d;
		end
	end

	// The safe state is left only through reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		safe_latched_q |=> safe_latched_q)
		else $error("safe state latch dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		safe_latched_q == (reason_q != sfs_pkg::REASON_NONE))
		else $error("latched reason disagrees with safe state latch");

	assert property (@(posedge clk) disable iff (!arst_n)
		!safe_latched_q |-> !lamp_q)
		else $error("lamp command set before safe state");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> time_q == $past(time_q + period_ext))
		else $error("time counter did not advance by one tick period");

endmodule

`default_nettype wire

@@ rtl/safety_fault_supervisor.sv @@
// Top level of the safety fault supervisor: channels, configuration registers, pipeline.
// An accepted tick item is held in the input stage, then evaluated into the result register.
// One tick item per cycle unless the result stalls; the state update uses compares and adds.
// A stalled result holds in the result register while one more item waits in the input stage.
// Reset (arst_n low) clears the safe-state latch, timers and time counter, sets daytime,
// and restores the configuration registers to their default values.
`default_nettype none

module safety_fault_supervisor #(
	parameter int TIME_BITS = sfs_pkg::TIME_BITS_DEF,
	parameter int SAMPLE_BITS = sfs_pkg::SAMPLE_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	sfs_tick_if.sink     tick,
	sfs_result_if.source result,
	sfs_cfg_if.sink      cfg
);

	sfs_pkg::cfg_t          cfg_q;
	logic [SAMPLE_BITS-1:0] day_threshold_q;

	logic                   valid_s1;
	sfs_pkg::tick_flags_t   flags_s1;
	logic [SAMPLE_BITS-1:0] level_s1;

	logic                   res_valid_q;
	sfs_pkg::result_t       res_q;
	sfs_pkg::result_t       res_d;

	logic                   adv;
	logic                   tick_acc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_threshold_q <= SAMPLE_BITS'(sfs_pkg::DAY_THRESHOLD_RST);
			cfg_q.max_faults <= sfs_pkg::MAX_FAULTS_RST;
			cfg_q.link_timeout_ms <= sfs_pkg::LINK_TIMEOUT_RST;
			cfg_q.tolerant_interval_ms <= sfs_pkg::TOLERANT_RST;
			cfg_q.tick_period_ms <= sfs_pkg::TICK_PERIOD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				sfs_pkg::REG_DAY_THRESHOLD: begin
					day_threshold_q <=
						SAMPLE_BITS'(cfg.data[sfs_pkg::DAY_THRESHOLD_BITS-1:0]);
				end
				sfs_pkg::REG_MAX_FAULTS: begin
					cfg_q.max_faults <= cfg.data[sfs_pkg::MAX_FAULTS_BITS-1:0];
				end
				sfs_pkg::REG_LINK_TIMEOUT: begin
					cfg_q.link_timeout_ms <= cfg.data[sfs_pkg::TIMEOUT_BITS-1:0];
				end
				sfs_pkg::REG_TOLERANT: begin
					cfg_q.tolerant_interval_ms <= cfg.data[sfs_pkg::TIMEOUT_BITS-1:0];
				end
				sfs_pkg::REG_TICK_PERIOD: begin
					cfg_q.tick_period_ms <= cfg.data[sfs_pkg::PERIOD_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign adv = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || adv;
	assign tick_acc = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			flags_s1.switch_valid <= tick.switch_valid;
			flags_s1.link_check_valid <= tick.link_check_valid;
			flags_s1.ambient_valid <= tick.ambient_valid;
			flags_s1.lamp_fault <= tick.lamp_fault;
			flags_s1.watchdog_status <= tick.watchdog_status;
			flags_s1.ext_reason <= tick.ext_reason;
			level_s1 <= tick.ambient_level;
		end
	end

	sfs_state #(
		.TIME_BITS(TIME_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.flags(flags_s1),
		.level(level_s1),
		.cfg(cfg_q),
		.day_threshold(day_threshold_q),
		.res(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.global_status = res_q.global_status;
	assign result.in_safe_state = res_q.in_safe_state;
	assign result.safe_reason = res_q.safe_reason;
	assign result.safe_lamp_command = res_q.safe_lamp_command;
	assign result.fault_count = res_q.fault_count;
	assign result.safe_entered_now = res_q.safe_entered_now;
	assign result.watchdog_fault = res_q.watchdog_fault;

	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid_q)
		else $error("evaluated item did not reach the result register");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !result.ready |-> !tick.ready)
		else $error("tick accepted while both stages are full and stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> valid_s1)
		else $error("accepted tick item lost from the input stage");

endmodule

`default_nettype wire
